// ===== hdl/b64e_pkg.sv =====
// Shared types, constants and the alphabet lookup for the base64 encoder.
package b64e_pkg;

  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam logic [6:0] PadChar = 7'h3D;

  typedef enum logic [1:0] {
    CNT_ONE   = 2'd1,
    CNT_TWO   = 2'd2,
    CNT_THREE = 2'd3,
    CNT_NONE  = 2'd0
  } b64e_cnt_e;

  typedef struct packed {
    logic [23:0] word;
    b64e_cnt_e   cnt;
    logic        last;
  } b64e_group_t;

  typedef struct packed {
    logic full;
    logic empty;
  } b64e_qstat_t;

  function automatic logic [6:0] sextet_char(input logic [5:0] s);
    logic [6:0] c;
    if (s < 6'd26) begin
      c = 7'h41 + {1'b0, s};
    end else if (s < 6'd52) begin
      c = 7'h61 + {1'b0, s} - 7'd26;
    end else if (s < 6'd62) begin
      c = 7'h30 + {1'b0, s} - 7'd52;
    end else if (s == 6'd62) begin
      c = 7'h2B;
    end else begin
      c = 7'h2F;
    end
    return c;
  endfunction

endpackage

// ===== hdl/b64e_front.sv =====
// Byte gathering front end: packs input bytes into 24-bit groups.
module b64e_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  accept_i,
  output logic                  push_o,
  output b64e_pkg::b64e_group_t group_o
);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] held_q, held_d;
  logic        full_grp;

  assign full_grp = (phase_q >= 2'd2);
  assign push_o   = accept_i && (last_byte_i || full_grp);

  always_comb begin
    group_o.last = last_byte_i;
    case (phase_q)
      2'd0: begin
        group_o.word = {data_byte_i, 16'h0000};
        group_o.cnt  = b64e_pkg::CNT_ONE;
      end
      2'd1: begin
        group_o.word = {held_q[15:8], data_byte_i, 8'h00};
        group_o.cnt  = b64e_pkg::CNT_TWO;
      end
      default: begin
        group_o.word = {held_q, data_byte_i};
        group_o.cnt  = b64e_pkg::CNT_THREE;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    if (accept_i) begin
      if (push_o) begin
        phase_d = 2'd0;
        held_d  = 16'h0000;
      end else if (phase_q == 2'd0) begin
        phase_d = 2'd1;
        held_d  = {data_byte_i, 8'h00};
      end else begin
        phase_d = 2'd2;
        held_d  = {held_q[15:8], data_byte_i};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= 2'd0;
      held_q  <= 16'h0000;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

// ===== hdl/b64e_queue.sv =====
// Small group queue between the front end and the character serializer.
module b64e_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  b64e_pkg::b64e_group_t push_data_i,
  input  logic                  pop_i,
  output b64e_pkg::b64e_group_t pop_data_o,
  output b64e_pkg::b64e_qstat_t stat_o
);

  b64e_pkg::b64e_group_t              mem_q [b64e_pkg::QDepth];
  logic [b64e_pkg::QPtrW-1:0]         wr_ptr_q, rd_ptr_q;
  logic [b64e_pkg::QCntW-1:0]         cnt_q;
  logic                               do_push, do_pop;

  assign stat_o.full  = (cnt_q == b64e_pkg::QCntW'(b64e_pkg::QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign pop_data_o   = mem_q[rd_ptr_q];

  function automatic logic [b64e_pkg::QPtrW-1:0] ptr_inc(input logic [b64e_pkg::QPtrW-1:0] p);
    logic [b64e_pkg::QPtrW-1:0] n;
    if (p == b64e_pkg::QPtrW'(b64e_pkg::QDepth - 1)) begin
      n = '0;
    end else begin
      n = p + 1'b1;
    end
    return n;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== hdl/b64e_back.sv =====
// Serializer: turns each queued group into four registered characters.
module b64e_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  b64e_pkg::b64e_group_t grp_i,
  input  logic                  grp_avail_i,
  output logic                  pop_o,
  output logic [6:0]            out_char_o,
  output logic                  out_last_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i
);

  b64e_pkg::b64e_group_t cur_q;
  logic                  cur_valid_q;
  logic [1:0]            idx_q;
  logic [6:0]            char_q;
  logic                  last_q, valid_q;
  logic                  emit, done;
  logic [6:0]            char_d;

  assign emit  = cur_valid_q && (!valid_q || out_ready_i);
  assign done  = emit && (idx_q == 2'd3);
  assign pop_o = grp_avail_i && (!cur_valid_q || done);

  always_comb begin
    case (idx_q)
      2'd0: char_d = b64e_pkg::sextet_char(cur_q.word[23:18]);
      2'd1: char_d = b64e_pkg::sextet_char(cur_q.word[17:12]);
      2'd2: char_d = (cur_q.cnt == b64e_pkg::CNT_ONE) ? b64e_pkg::PadChar
                     : b64e_pkg::sextet_char(cur_q.word[11:6]);
      default: char_d = (cur_q.cnt == b64e_pkg::CNT_THREE)
                        ? b64e_pkg::sextet_char(cur_q.word[5:0]) : b64e_pkg::PadChar;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= grp_i;
    end
    if (emit) begin
      char_q <= char_d;
      last_q <= (idx_q == 2'd3) && cur_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= 2'd0;
      valid_q     <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_valid_q <= 1'b1;
      end else if (done) begin
        cur_valid_q <= 1'b0;
      end
      if (emit) begin
        idx_q <= idx_q + 2'd1;
      end
      if (emit) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  assign out_char_o  = char_q;
  assign out_last_o  = last_q;
  assign out_valid_o = valid_q;

endmodule

// ===== hdl/base64_encoder_top.sv =====
// Base64 encoder top level: byte stream in, ASCII character stream out.
// Bytes enter one per cycle while the two-group queue has room; each third
// byte, or a byte flagged as last, closes a group that the serializer turns
// into four characters, one per cycle while the output is ready, padded with
// '=' for a short final group and with tlast on the final character. The
// sustained rate is set by the serializer, which emits four characters for
// each three bytes; the first character of a group passes through the queue,
// the serializer's group register and its character register.
module base64_encoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] data_byte
  input  logic       s_axis_tlast_i,  // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [6:0] out_char, [7] zero
  output logic       m_axis_tlast_o   // out_last
);

  b64e_pkg::b64e_group_t push_grp, pop_grp;
  b64e_pkg::b64e_qstat_t qstat;
  logic                  accept, push, pop;
  logic [6:0]            out_char;

  assign s_axis_tready_o = !qstat.full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  b64e_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .accept_i    (accept),
    .push_o      (push),
    .group_o     (push_grp)
  );

  b64e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_grp),
    .pop_i       (pop),
    .pop_data_o  (pop_grp),
    .stat_o      (qstat)
  );

  b64e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_i       (pop_grp),
    .grp_avail_i (!qstat.empty),
    .pop_o       (pop),
    .out_char_o  (out_char),
    .out_last_o  (m_axis_tlast_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {1'b0, out_char};

endmodule

// ===== hdl/b64e_checker.sv =====
// Port-level checker for the base64 encoder, bound to the top level.
module b64e_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic       out_acc;
  logic       pad_seen_q;
  logic [1:0] pos_q;

  assign out_acc = m_axis_tvalid_o && m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_seen_q <= 1'b0;
      pos_q      <= 2'd0;
    end else if (out_acc) begin
      pad_seen_q <= (m_axis_tdata_o[6:0] == b64e_pkg::PadChar) && !m_axis_tlast_o;
      pos_q      <= pos_q + 2'd1;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o)
      && $stable(m_axis_tlast_o))
    else $error("output item changed while stalled");

  a_ascii: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[7])
    else $error("output character outside 7-bit range");

  a_pad_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && pad_seen_q |-> m_axis_tdata_o[6:0] == b64e_pkg::PadChar && m_axis_tlast_o)
    else $error("padding not followed by final padding");

  a_quad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast_o |-> pos_q == 2'd3)
    else $error("final character not at end of a four-character group");

endmodule

bind base64_encoder_top b64e_checker u_b64e_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
